// ===== hdl/fragrx_pkg.sv =====
package fragrx_pkg;

    localparam logic [7:0] PAYLOAD_MAX = 8'd250;

    localparam logic [2:0] TYPE_DATA = 3'd0;
    localparam logic [2:0] TYPE_ACK  = 3'd1;

    typedef enum logic [2:0] {
        ACT_IGNORE  = 3'd0,
        ACT_STORE   = 3'd1,
        ACT_REACK   = 3'd2,
        ACT_NACK    = 3'd3,
        ACT_ACKSEEN = 3'd4
    } action_t;

    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  msg_type;
        logic [31:0] message_id;
        logic [7:0]  frag_seq;
        logic [7:0]  frag_total;
        logic [7:0]  payload_bytes;
        logic [47:0] sender_addr;
    } hdr_t;

    typedef struct packed {
        action_t     action;
        logic [47:0] reply_addr;
        logic [31:0] reply_msg_id;
        logic [7:0]  reply_seq;
        logic [7:0]  store_len;
        logic        new_session;
        logic        message_done;
    } res_t;

endpackage

// ===== hdl/fragrx_hdr_if.sv =====
interface fragrx_hdr_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [2:0]  msg_type;
    logic [31:0] message_id;
    logic [7:0]  frag_seq;
    logic [7:0]  frag_total;
    logic [7:0]  payload_bytes;
    logic [47:0] sender_addr;

    modport source (
        output valid, frame_ok, msg_type, message_id, frag_seq, frag_total,
               payload_bytes, sender_addr,
        input  ready
    );

    modport sink (
        input  valid, frame_ok, msg_type, message_id, frag_seq, frag_total,
               payload_bytes, sender_addr,
        output ready
    );
endinterface

// ===== hdl/fragrx_res_if.sv =====
interface fragrx_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [47:0] reply_addr;
    logic [31:0] reply_msg_id;
    logic [7:0]  reply_seq;
    logic [7:0]  store_len;
    logic        new_session;
    logic        message_done;

    modport source (
        output valid, action, reply_addr, reply_msg_id, reply_seq, store_len,
               new_session, message_done,
        input  ready
    );

    modport sink (
        input  valid, action, reply_addr, reply_msg_id, reply_seq, store_len,
               new_session, message_done,
        output ready
    );
endinterface

// ===== hdl/fragrx_in_stage.sv =====
module fragrx_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    fragrx_hdr_if.sink         hdr,
    input  logic               advance,
    output logic               hdr_valid,
    output fragrx_pkg::hdr_t   hdr_word
);
    import fragrx_pkg::*;

    logic valid_reg;
    logic valid_next;
    hdr_t hdr_reg;
    logic take;

    assign hdr.ready  = !valid_reg || advance;
    assign take       = hdr.valid && hdr.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hdr_reg.frame_ok      <= hdr.frame_ok;
            hdr_reg.msg_type      <= hdr.msg_type;
            hdr_reg.message_id    <= hdr.message_id;
            hdr_reg.frag_seq      <= hdr.frag_seq;
            hdr_reg.frag_total    <= hdr.frag_total;
            hdr_reg.payload_bytes <= hdr.payload_bytes;
            hdr_reg.sender_addr   <= hdr.sender_addr;
        end
    end

    assign hdr_valid = valid_reg;
    assign hdr_word  = hdr_reg;

endmodule

// ===== hdl/fragrx_decide.sv =====
module fragrx_decide (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  fragrx_pkg::hdr_t   hdr,
    output fragrx_pkg::res_t   result
);
    import fragrx_pkg::*;

    logic [31:0] last_id_reg, last_id_next;
    logic [31:0] session_id_reg, session_id_next;
    logic        session_open_reg, session_open_next;
    logic [7:0]  expected_seq_reg, expected_seq_next;

    logic        is_data;
    logic [31:0] id_diff;
    logic        newer;
    logic        open_new;
    logic        go;
    logic [7:0]  exp_eff;
    logic        is_last;
    logic        do_store;

    always_comb
    begin
        is_data  = hdr.frame_ok && (hdr.msg_type == TYPE_DATA);
        // serial compare: newer when difference is nonzero with sign bit clear
        id_diff  = hdr.message_id - last_id_reg;
        newer    = (id_diff != 32'd0) && !id_diff[31];
        open_new = is_data && (hdr.frag_seq == 8'd0) && newer;
        go       = open_new
                   || (is_data && (hdr.frag_seq != 8'd0) && session_open_reg
                       && (hdr.message_id == session_id_reg));
        exp_eff  = open_new ? 8'd0 : expected_seq_reg;
        is_last  = ({1'b0, hdr.frag_seq} + 9'd1) == {1'b0, hdr.frag_total};
        do_store = go && (hdr.frag_seq == exp_eff);

        result              = '0;
        result.action       = ACT_IGNORE;
        result.new_session  = open_new;
        if (hdr.frame_ok && (hdr.msg_type == TYPE_ACK))
        begin
            result.action = ACT_ACKSEEN;
        end
        else if (go)
        begin
            result.reply_addr   = hdr.sender_addr;
            result.reply_msg_id = hdr.message_id;
            if (do_store)
            begin
                result.action       = ACT_STORE;
                result.reply_seq    = hdr.frag_seq;
                result.store_len    = (hdr.payload_bytes > PAYLOAD_MAX) ?
                                      PAYLOAD_MAX : hdr.payload_bytes;
                result.message_done = is_last;
            end
            else if (hdr.frag_seq > exp_eff)
            begin
                result.action    = ACT_NACK;
                result.reply_seq = exp_eff;
            end
            else
            begin
                result.action    = ACT_REACK;
                result.reply_seq = hdr.frag_seq;
            end
        end

        last_id_next      = last_id_reg;
        session_id_next   = session_id_reg;
        session_open_next = session_open_reg;
        expected_seq_next = exp_eff;
        if (open_new)
        begin
            last_id_next      = hdr.message_id;
            session_id_next   = hdr.message_id;
            session_open_next = 1'b1;
        end
        if (do_store)
        begin
            expected_seq_next = exp_eff + 8'd1;
            if (is_last)
            begin
                session_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_id_reg      <= 32'd0;
            session_id_reg   <= 32'd0;
            session_open_reg <= 1'b0;
            expected_seq_reg <= 8'd0;
        end
        else if (fire)
        begin
            last_id_reg      <= last_id_next;
            session_id_reg   <= session_id_next;
            session_open_reg <= session_open_next;
            expected_seq_reg <= expected_seq_next;
        end
    end

`ifndef SYNTHESIS
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.message_done) |=> !session_open_reg)
        else $error("session still open after last fragment");

    a_open_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.new_session) |-> (result.action == ACT_STORE))
        else $error("new session without storing first fragment");

    a_open_tracks_id: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.new_session) |=>
            (last_id_reg == $past(hdr.message_id)) && (session_id_reg == last_id_reg))
        else $error("session id not taken from opening fragment");

    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(expected_seq_reg) && $stable(session_open_reg))
        else $error("state changed without a word");
`endif

endmodule

// ===== hdl/fragment_receiver_antireplay.sv =====
// Receive-side decision unit for a stop-and-wait fragment protocol with a
// replay window. Each header word gives exactly one result word: ignore,
// store and ack, re-ack stale, nack the expected sequence, or ack seen. A
// data fragment with sequence 0 opens a session only when its message id is
// newer than the last accepted id under a 32-bit wrap-around compare. The
// block takes one header word per cycle unless the result side stalls: a
// header is registered at accept, decided by short logic against the session
// registers, and the result is loaded into an output register when that
// register is empty or its word is being taken, and is valid from there.
// A stalled result stalls the input register behind it; there is no other
// back-pressure. The block is ready right after reset.
module fragment_receiver_antireplay (
    input  logic          clk,
    input  logic          rst_n,
    fragrx_hdr_if.sink    hdr,
    fragrx_res_if.source  res
);
    import fragrx_pkg::*;

    logic advance;
    logic hdr_valid;
    hdr_t hdr_word;
    logic fire;
    res_t result;

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    assign advance = res.ready || !out_valid_reg;
    assign fire    = hdr_valid && advance;

    fragrx_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr       (hdr),
        .advance   (advance),
        .hdr_valid (hdr_valid),
        .hdr_word  (hdr_word)
    );

    fragrx_decide u_decide (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .hdr    (hdr_word),
        .result (result)
    );

    assign out_valid_next = fire || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.action       = res_reg.action;
    assign res.reply_addr   = res_reg.reply_addr;
    assign res.reply_msg_id = res_reg.reply_msg_id;
    assign res.reply_seq    = res_reg.reply_seq;
    assign res.store_len    = res_reg.store_len;
    assign res.new_session  = res_reg.new_session;
    assign res.message_done = res_reg.message_done;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import fragrx_pkg::*;

    localparam logic [2:0] TYPE_NACK      = 3'd2;
    localparam int         NUM_TYPES      = 8;
    localparam logic [47:0] ADDR_ONES     = 48'hFFFF_FFFF_FFFF;
    localparam int         STALL_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         RANDOM_TARGET  = 1600;
    localparam int         TAIL_TARGET    = 1750;

    logic clk = 1'b0;
    logic rst_n;

    fragrx_hdr_if hdr_if();
    fragrx_res_if res_if();

    fragment_receiver_antireplay dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_if),
        .res   (res_if)
    );

    always #1 clk = ~clk;

    // receiver-side window state as the block should hold it
    logic [31:0] newest_id;
    logic [31:0] open_id;
    logic        open_flag;
    logic [7:0]  next_seq;

    res_t pending_decisions[$];

    bit sender_gaps;
    bit receiver_stalls;
    int stall_left;
    int quiet_cycles;
    int errors;
    int results_checked;
    int headers_sent;
    int headers_acted;
    int action_hits[NUM_TYPES];
    int sessions_opened;
    int messages_done;

    function automatic res_t decide_header(input hdr_t h);
        res_t        r;
        logic [31:0] diff;
        logic        go;
        r = '0;
        r.action = ACT_IGNORE;
        go = 1'b0;
        if (h.frame_ok) begin
            if (h.msg_type == TYPE_ACK) begin
                r.action = ACT_ACKSEEN;
            end
            else if (h.msg_type == TYPE_DATA) begin
                if (h.frag_seq == 8'd0) begin
                    diff = h.message_id - newest_id;
                    // serial compare: newer when nonzero and within half the id space
                    if (diff != 32'd0 && !diff[31]) begin
                        newest_id = h.message_id;
                        open_id = h.message_id;
                        open_flag = 1'b1;
                        next_seq = 8'd0;
                        r.new_session = 1'b1;
                        go = 1'b1;
                    end
                end
                else if (open_flag && h.message_id == open_id) begin
                    go = 1'b1;
                end
                if (go) begin
                    r.reply_addr = h.sender_addr;
                    r.reply_msg_id = h.message_id;
                    if (h.frag_seq == next_seq) begin
                        r.action = ACT_STORE;
                        r.reply_seq = h.frag_seq;
                        r.store_len = (h.payload_bytes > PAYLOAD_MAX) ? PAYLOAD_MAX
                                                                      : h.payload_bytes;
                        // a total of zero never matches, so the session stays open
                        if ({1'b0, h.frag_seq} + 9'd1 == {1'b0, h.frag_total}) begin
                            open_flag = 1'b0;
                            r.message_done = 1'b1;
                        end
                        next_seq = next_seq + 8'd1;
                    end
                    else if (h.frag_seq > next_seq) begin
                        r.action = ACT_NACK;
                        r.reply_seq = next_seq;
                    end
                    else begin
                        r.action = ACT_REACK;
                        r.reply_seq = h.frag_seq;
                    end
                end
            end
        end
        action_hits[int'(r.action)]++;
        if (r.new_session) sessions_opened++;
        if (r.message_done) messages_done++;
        return r;
    endfunction

    function automatic hdr_t make_hdr(input logic ok, input logic [2:0] typ,
                                      input logic [31:0] id, input logic [7:0] seq,
                                      input logic [7:0] total, input logic [7:0] plen,
                                      input logic [47:0] addr);
        hdr_t h;
        h.frame_ok = ok;
        h.msg_type = typ;
        h.message_id = id;
        h.frag_seq = seq;
        h.frag_total = total;
        h.payload_bytes = plen;
        h.sender_addr = addr;
        return h;
    endfunction

    function automatic logic [47:0] rand_addr();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_hdr(input hdr_t h);
        res_t r;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            hdr_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        hdr_if.valid <= 1'b1;
        hdr_if.frame_ok <= h.frame_ok;
        hdr_if.msg_type <= h.msg_type;
        hdr_if.message_id <= h.message_id;
        hdr_if.frag_seq <= h.frag_seq;
        hdr_if.frag_total <= h.frag_total;
        hdr_if.payload_bytes <= h.payload_bytes;
        hdr_if.sender_addr <= h.sender_addr;
        @(posedge clk);
        while (!hdr_if.ready) @(posedge clk);
        r = decide_header(h);
        pending_decisions.push_back(r);
        headers_sent++;
        if (r.action != ACT_IGNORE) headers_acted++;
    endtask

    task automatic wait_all_decided();
        hdr_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_decisions.size() != 0) @(posedge clk);
    endtask

    task automatic send_data(input logic [31:0] id, input logic [7:0] seq,
                             input logic [7:0] total, input logic [47:0] addr);
        send_hdr(make_hdr(1'b1, TYPE_DATA, id, seq, total, 8'($urandom_range(0, 255)), addr));
    endtask

    task automatic send_noise();
        logic [31:0] id;
        id = $urandom_range(0, 1) ? open_id : $urandom;
        send_hdr(make_hdr(1'($urandom), 3'($urandom), id, 8'($urandom), 8'($urandom),
                          8'($urandom), rand_addr()));
    endtask

    // one message in order, with duplicates, skips, foreign ids and noise mixed in
    task automatic send_message(input logic [31:0] id, input logic [7:0] total);
        logic [47:0] addr;
        logic [7:0]  seq;
        int          nfrag;
        int          ahead;
        addr = rand_addr();
        nfrag = (total == 8'd0) ? $urandom_range(1, 10) : int'(total);
        if ($urandom_range(0, 7) == 0) nfrag = $urandom_range(1, nfrag);
        for (int i = 0; i < nfrag; i++) begin
            seq = 8'(i);
            case ($urandom_range(0, 15))
                0: begin
                    ahead = i + $urandom_range(1, 3);
                    send_data(id, (ahead > 255) ? 8'd255 : 8'(ahead), total, addr);
                end
                1: if (i > 0) send_data(id, 8'($urandom_range(0, i - 1)), total, addr);
                2: send_noise();
                3: send_data(id ^ (32'd1 << $urandom_range(0, 31)),
                             8'($urandom_range(1, 255)), total, addr);
                default: ;
            endcase
            send_data(id, seq, total, addr);
        end
    endtask

    task automatic send_random_message();
        logic [31:0] id;
        logic [7:0]  total;
        case ($urandom_range(0, 15))
            0: id = newest_id - $urandom_range(0, 50);
            1: id = $urandom;
            2: id = newest_id + 32'h8000_0000;
            3: id = newest_id + 32'h7FFF_FFFF;
            default: id = newest_id + $urandom_range(1, 300);
        endcase
        case ($urandom_range(0, 31))
            0, 1: total = 8'd0;
            2: total = 8'($urandom_range(7, 40));
            default: total = 8'($urandom_range(1, 6));
        endcase
        send_message(id, total);
        if ($urandom_range(0, 3) == 0) send_noise();
    endtask

    task automatic test_directed();
        send_hdr(make_hdr(1'b0, TYPE_DATA, 32'd5, 8'd0, 8'd1, 8'd10, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_ACK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, ADDR_ONES));
        for (int t = int'(TYPE_NACK); t < NUM_TYPES; t++)
            send_hdr(make_hdr(1'b1, 3'(t), 32'hFFFF_FFFF, 8'd0, 8'd1, 8'd5, ADDR_ONES));
        // equal and exactly half-range ids are not newer
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'd0, 8'd0, 8'd1, 8'd1, 48'd0));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h8000_0000, 8'd0, 8'd1, 8'd1, 48'd0));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd0, 8'd3, 8'd255, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFE, 8'd1, 8'd3, 8'd9, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd2, 8'd3, 8'd9, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd1, 8'd3, 8'd0, 48'd0));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd1, 8'd3, 8'd7, 48'd0));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd2, 8'd3, 8'd250, ADDR_ONES));
        // session closed, and the same id again at sequence zero
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd2, 8'd3, 8'd250, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'h7FFF_FFFF, 8'd0, 8'd3, 8'd1, ADDR_ONES));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'hFFFF_FFFF, 8'd0, 8'd3, 8'd1, ADDR_ONES));
        // total of zero keeps the session open
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'hFFFF_FFFE, 8'd0, 8'd0, 8'd251, 48'd1));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'hFFFF_FFFE, 8'd1, 8'd0, 8'd100, 48'd1));
        // id wraps past zero and is still newer
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'd4, 8'd0, 8'd1, 8'd33, 48'h8000_0000_0000));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'd4, 8'd1, 8'd1, 8'd33, 48'h8000_0000_0000));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'd5, 8'd0, 8'd2, 8'd44, 48'h0000_FFFF_0000));
        send_hdr(make_hdr(1'b1, TYPE_DATA, 32'd5, 8'd255, 8'd2, 8'd44, 48'h0000_FFFF_0000));
    endtask

    task automatic test_seq_wrap();
        logic [31:0] id;
        logic [47:0] addr;
        id = newest_id + 32'd1;
        addr = rand_addr();
        for (int i = 0; i < 256; i++) send_data(id, 8'(i), 8'd0, addr);
        // counter has wrapped back to zero
        send_data(id, 8'd1, 8'd0, addr);
        send_data(id, 8'd0, 8'd0, addr);
        id = newest_id + 32'd1;
        for (int i = 0; i < 255; i++) send_data(id, 8'(i), 8'd255, addr);
        wait_all_decided();
    endtask

    task automatic test_random_traffic();
        int phase_start;
        phase_start = headers_sent;
        while (headers_sent < RANDOM_TARGET) begin
            send_random_message();
            if (headers_sent - phase_start > 500 && headers_sent - phase_start < 520)
                wait_all_decided();
        end
    endtask

    task automatic test_quiet_tail();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        while (headers_sent < TAIL_TARGET) send_random_message();
        hdr_if.valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            res_if.ready <= 1'b0;
        end
        else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        res_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (pending_decisions.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word at %0t: act=%0d", $time, res_if.action);
            end
            else begin
                want = pending_decisions.pop_front();
                if (res_if.action !== want.action || res_if.reply_addr !== want.reply_addr
                    || res_if.reply_msg_id !== want.reply_msg_id
                    || res_if.reply_seq !== want.reply_seq
                    || res_if.store_len !== want.store_len
                    || res_if.new_session !== want.new_session
                    || res_if.message_done !== want.message_done) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at %0t: exp act=%0d addr=%h id=%h seq=%0d len=%0d %s",
                                 $time, want.action, want.reply_addr, want.reply_msg_id,
                                 want.reply_seq, want.store_len,
                                 $sformatf("new=%b done=%b", want.new_session,
                                           want.message_done));
                        $display("    got act=%0d addr=%h id=%h seq=%0d len=%0d new=%b done=%b",
                                 res_if.action, res_if.reply_addr, res_if.reply_msg_id,
                                 res_if.reply_seq, res_if.store_len, res_if.new_session,
                                 res_if.message_done);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("fragment_receiver_antireplay verification failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n = 1'b0;
        hdr_if.valid = 1'b0;
        hdr_if.frame_ok = 1'b0;
        hdr_if.msg_type = TYPE_DATA;
        hdr_if.message_id = 32'd0;
        hdr_if.frag_seq = 8'd0;
        hdr_if.frag_total = 8'd0;
        hdr_if.payload_bytes = 8'd0;
        hdr_if.sender_addr = 48'd0;
        res_if.ready = 1'b0;
        newest_id = 32'd0;
        open_id = 32'd0;
        open_flag = 1'b0;
        next_seq = 8'd0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        stall_left = 0;
        quiet_cycles = 0;
        errors = 0;
        results_checked = 0;
        headers_sent = 0;
        headers_acted = 0;
        sessions_opened = 0;
        messages_done = 0;
        foreach (action_hits[i]) action_hits[i] = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_seq_wrap();
        test_random_traffic();
        test_quiet_tail();

        wait_all_decided();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_decisions.size() != 0) errors++;

        $display("headers sent %0d (%0d acted on): stored %0d, re-acked %0d, nacked %0d, %s %0d",
                 headers_sent, headers_acted, action_hits[int'(ACT_STORE)],
                 action_hits[int'(ACT_REACK)], action_hits[int'(ACT_NACK)], "ack-seen",
                 action_hits[int'(ACT_ACKSEEN)]);
        $display("sessions opened %0d, messages completed %0d, result words checked %0d",
                 sessions_opened, messages_done, results_checked);
        if (errors == 0)
            $display("fragment_receiver_antireplay verification clean");
        else
            $display("fragment_receiver_antireplay verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/fragrx_pkg.sv
hdl/fragrx_hdr_if.sv
hdl/fragrx_res_if.sv
hdl/fragrx_in_stage.sv
hdl/fragrx_decide.sv
hdl/fragment_receiver_antireplay.sv
tb/tb_top.sv
